[sv/cfd_pkg.sv]
// Shared types and constants for the first-contact detector.
// Used by cfd_core and first_contact_detector; depends on nothing.
package cfd_pkg;

    // Defaults for the top-level parameters
    localparam int BALL_COUNT_DEF = 32;
    localparam int FRAME_LIMIT_DEF = 65536;
    localparam int COORD_BITS_DEF = 16;

    // Field widths of the stream words
    localparam int POS_W = 16;
    localparam int ID_W = 5;
    localparam int MODE_W = 2;
    localparam int FRAME_OUT_W = 16;
    localparam int THRESH_W = 16;
    localparam int THRESH_SQ_W = 2 * THRESH_W;
    localparam int S_DATA_W = 40;   // 38 used bits, padded to bytes
    localparam int M_DATA_W = 24;   // 22 used bits, padded to bytes

    // Contact threshold after reset: 25.0 px in 12.4 fixed point
    localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd400;

    // Sample kinds carried in tuser
    typedef enum logic [MODE_W-1:0] {
        MODE_CUE   = 2'd0,
        MODE_BALL  = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_IDLE  = 2'd3
    } mode_t;

    // One input word, unpacked
    typedef struct packed {
        mode_t            mode;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic             visible;
        logic [ID_W-1:0]  ball_id;
        logic             last_in_frame;
    } item_t;

endpackage

[sv/first_contact_detector.sv]
// First-contact detector: input word register, threshold-square register and core.
// A frame's closing word passes the input word register, then sets the result register
// in cfd_core. Throughput: one word per cycle (combinational distance and compare, then
// latch in cfd_core); a closing word waits only while an unread result is held.
// Synchronous active-low reset clears tracking and sets the threshold to 25.0 px.
// Depends on cfd_pkg and cfd_core.
module first_contact_detector #(
    parameter int BALL_COUNT  = cfd_pkg::BALL_COUNT_DEF,
    parameter int FRAME_LIMIT = cfd_pkg::FRAME_LIMIT_DEF,
    parameter int COORD_BITS  = cfd_pkg::COORD_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration: contact_threshold
    input  logic                              cfg_we,
    input  logic [cfd_pkg::THRESH_W-1:0]      cfg_wdata,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata: [15:0] pos_x, [31:16] pos_y, [32] visible, [37:33] ball_id, [39:38] zero
    input  logic [cfd_pkg::S_DATA_W-1:0]      s_tdata,
    // s_tuser: [1:0] mode
    input  logic [cfd_pkg::MODE_W-1:0]        s_tuser,
    input  logic                              s_tlast,
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata: [0] contact_found, [5:1] touched_ball, [21:6] contact_frame, [23:22] zero
    output logic [cfd_pkg::M_DATA_W-1:0]      m_tdata
);

    localparam logic [cfd_pkg::THRESH_SQ_W-1:0] THRESH_SQ_RESET =
        cfd_pkg::THRESH_SQ_W'(cfd_pkg::THRESH_RESET) *
        cfd_pkg::THRESH_SQ_W'(cfd_pkg::THRESH_RESET);

    logic                             in_valid_reg;
    cfd_pkg::item_t                   in_item_reg;
    logic [cfd_pkg::THRESH_SQ_W-1:0]  thresh_sq_reg;
    logic                             core_take;
    cfd_pkg::item_t                   s_item;

    // unpack the incoming word
    assign s_item.mode          = cfd_pkg::mode_t'(s_tuser);
    assign s_item.pos_x         = s_tdata[15:0];
    assign s_item.pos_y         = s_tdata[31:16];
    assign s_item.visible       = s_tdata[32];
    assign s_item.ball_id       = s_tdata[37:33];
    assign s_item.last_in_frame = s_tlast;

    // input register refills whenever the core takes its word
    assign s_tready = !in_valid_reg || core_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg <= s_item;
        end
    end

    // threshold kept squared; the square is formed on write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_sq_reg <= THRESH_SQ_RESET;
        end else if (cfg_we) begin
            thresh_sq_reg <= cfd_pkg::THRESH_SQ_W'(cfg_wdata) *
                             cfd_pkg::THRESH_SQ_W'(cfg_wdata);
        end
    end

    cfd_core #(
        .BALL_COUNT  (BALL_COUNT),
        .FRAME_LIMIT (FRAME_LIMIT),
        .COORD_BITS  (COORD_BITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item       (in_item_reg),
        .item_valid (in_valid_reg),
        .item_take  (core_take),
        .thresh_sq  (thresh_sq_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

[sv/cfd_dist.sv]
// Squared distance between a ball sample and the stored cue position.
// Pure combinational; depends on nothing but its parameter.
module cfd_dist #(
    parameter int CW = 16
) (
    input  logic [CW-1:0]   ball_x,
    input  logic [CW-1:0]   ball_y,
    input  logic [CW-1:0]   cue_x,
    input  logic [CW-1:0]   cue_y,
    output logic [2*CW:0]   dist_sq
);

    logic [CW-1:0]   dx;
    logic [CW-1:0]   dy;
    logic [2*CW-1:0] dx_sq;
    logic [2*CW-1:0] dy_sq;

    // absolute differences
    assign dx = (ball_x >= cue_x) ? (ball_x - cue_x) : (cue_x - ball_x);
    assign dy = (ball_y >= cue_y) ? (ball_y - cue_y) : (cue_y - ball_y);

    // two independent squares and one sum
    assign dx_sq = (2*CW)'(dx) * (2*CW)'(dx);
    assign dy_sq = (2*CW)'(dy) * (2*CW)'(dy);
    assign dist_sq = (2*CW+1)'(dx_sq) + (2*CW+1)'(dy_sq);

endmodule

[sv/cfd_core.sv]
// Per-frame nearest-ball tracking, first-contact latch and result register.
// Depends on cfd_pkg and cfd_dist.
module cfd_core #(
    parameter int BALL_COUNT  = cfd_pkg::BALL_COUNT_DEF,
    parameter int FRAME_LIMIT = cfd_pkg::FRAME_LIMIT_DEF,
    parameter int COORD_BITS  = cfd_pkg::COORD_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  cfd_pkg::item_t                     item,
    input  logic                               item_valid,
    output logic                               item_take,
    input  logic [cfd_pkg::THRESH_SQ_W-1:0]    thresh_sq,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // m_tdata: [0] contact_found, [5:1] touched_ball, [21:6] contact_frame
    output logic [cfd_pkg::M_DATA_W-1:0]       m_tdata
);

    localparam int CW = (COORD_BITS < cfd_pkg::POS_W) ? COORD_BITS : cfd_pkg::POS_W;
    localparam int D2W = 2 * CW + 1;
    localparam int CMPW = (D2W > cfd_pkg::THRESH_SQ_W) ? D2W : cfd_pkg::THRESH_SQ_W;
    localparam int FW = $clog2(FRAME_LIMIT);
    localparam int IDCW = 9;
    localparam logic [FW-1:0] FRAME_MAX = FW'(FRAME_LIMIT - 1);
    localparam logic [IDCW-1:0] BALL_LIMIT = IDCW'(BALL_COUNT);

    // cue and per-frame best state
    logic [CW-1:0]                    cue_x_reg, cue_x_next;
    logic [CW-1:0]                    cue_y_reg, cue_y_next;
    logic                             cue_vis_reg, cue_vis_next;
    logic [cfd_pkg::THRESH_SQ_W-1:0]  best_dist_reg, best_dist_next;
    logic [cfd_pkg::ID_W-1:0]         best_ball_reg, best_ball_next;
    logic                             best_valid_reg, best_valid_next;
    logic [FW-1:0]                    frame_cnt_reg, frame_cnt_next;
    logic                             latched_reg, latched_next;
    logic [cfd_pkg::ID_W-1:0]         latched_ball_reg, latched_ball_next;
    logic [cfd_pkg::FRAME_OUT_W-1:0]  latched_frame_reg, latched_frame_next;
    logic                             m_valid_reg, m_valid_next;
    logic [cfd_pkg::M_DATA_W-1:0]     m_data_reg, m_data_next;

    logic [D2W-1:0] dist_sq;
    logic           emits;
    logic           id_ok;
    logic           hit;

    cfd_dist #(.CW(CW)) u_dist (
        .ball_x  (item.pos_x[CW-1:0]),
        .ball_y  (item.pos_y[CW-1:0]),
        .cue_x   (cue_x_reg),
        .cue_y   (cue_y_reg),
        .dist_sq (dist_sq)
    );

    // a word that closes a frame needs room in the result register
    assign emits = ((item.mode == cfd_pkg::MODE_CUE) || (item.mode == cfd_pkg::MODE_BALL))
                   && item.last_in_frame;
    assign item_take = item_valid && (!emits || !m_valid_reg || m_tready);

    assign id_ok = IDCW'(item.ball_id) < BALL_LIMIT;
    assign hit = (item.mode == cfd_pkg::MODE_BALL) && item.visible && cue_vis_reg && id_ok
                 && (CMPW'(dist_sq) < CMPW'(thresh_sq))
                 && (!best_valid_reg || (CMPW'(dist_sq) < CMPW'(best_dist_reg)));

    // next-state logic for one processed word
    always_comb begin
        cue_x_next         = cue_x_reg;
        cue_y_next         = cue_y_reg;
        cue_vis_next       = cue_vis_reg;
        best_dist_next     = best_dist_reg;
        best_ball_next     = best_ball_reg;
        best_valid_next    = best_valid_reg;
        frame_cnt_next     = frame_cnt_reg;
        latched_next       = latched_reg;
        latched_ball_next  = latched_ball_reg;
        latched_frame_next = latched_frame_reg;
        m_valid_next       = m_valid_reg && !m_tready;
        m_data_next        = m_data_reg;

        if (item_take) begin
            case (item.mode)
                cfd_pkg::MODE_CLEAR: begin
                    cue_x_next         = '0;
                    cue_y_next         = '0;
                    cue_vis_next       = 1'b0;
                    best_valid_next    = 1'b0;
                    best_ball_next     = '0;
                    frame_cnt_next     = '0;
                    latched_next       = 1'b0;
                    latched_ball_next  = '0;
                    latched_frame_next = '0;
                end
                cfd_pkg::MODE_CUE: begin
                    cue_x_next      = item.pos_x[CW-1:0];
                    cue_y_next      = item.pos_y[CW-1:0];
                    cue_vis_next    = item.visible;
                    best_valid_next = 1'b0;
                    best_ball_next  = '0;
                end
                cfd_pkg::MODE_BALL: begin
                    if (hit) begin
                        best_dist_next  = cfd_pkg::THRESH_SQ_W'(dist_sq);
                        best_ball_next  = item.ball_id;
                        best_valid_next = 1'b1;
                    end
                end
                default: begin
                end
            endcase

            // frame close: latch once, report, clear best, count frame
            if (emits) begin
                if (!latched_reg && best_valid_next) begin
                    latched_next       = 1'b1;
                    latched_ball_next  = best_ball_next;
                    latched_frame_next = cfd_pkg::FRAME_OUT_W'(frame_cnt_reg);
                end
                best_valid_next = 1'b0;
                best_ball_next  = '0;
                frame_cnt_next  = (frame_cnt_reg == FRAME_MAX) ? '0 : frame_cnt_reg + 1'b1;
                m_valid_next    = 1'b1;
                m_data_next     = cfd_pkg::M_DATA_W'({latched_frame_next, latched_ball_next,
                                                      latched_next});
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cue_vis_reg       <= 1'b0;
            best_valid_reg    <= 1'b0;
            best_ball_reg     <= '0;
            frame_cnt_reg     <= '0;
            latched_reg       <= 1'b0;
            latched_ball_reg  <= '0;
            latched_frame_reg <= '0;
            cue_x_reg         <= '0;
            cue_y_reg         <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            cue_vis_reg       <= cue_vis_next;
            best_valid_reg    <= best_valid_next;
            best_ball_reg     <= best_ball_next;
            frame_cnt_reg     <= frame_cnt_next;
            latched_reg       <= latched_next;
            latched_ball_reg  <= latched_ball_next;
            latched_frame_reg <= latched_frame_next;
            cue_x_reg         <= cue_x_next;
            cue_y_reg         <= cue_y_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    // payload registers, only read when the matching valid bit is set
    always_ff @(posedge aclk) begin
        best_dist_reg <= best_dist_next;
        m_data_reg    <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
